/* hdl/onewire_slave_link_core_defines.svh */
// ----------------------------------------------------------------------------
// onewire_slave_link_core_defines.svh
// assertion macros shared by the one-wire slave link checkers
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_SLAVE_LINK_CORE_DEFINES_SVH
`define ONEWIRE_SLAVE_LINK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define OSL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("one-wire link check failed");

// next-cycle implication, sampled on clk, quiet during rst
`define OSL_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("one-wire link check failed");

`endif

/* hdl/osl_pkg.sv */
// ----------------------------------------------------------------------------
// osl_pkg
// types, codes and helpers for the one-wire slave link layer
// ----------------------------------------------------------------------------
package osl_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  // request codes
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_RX   = 2'd1;
  localparam logic [1:0] REQ_TX   = 2'd2;
  localparam logic [1:0] REQ_BAD  = 2'd3;

  // link state codes seen by the user
  localparam logic [1:0] LINK_WAIT_RESET = 2'd0;
  localparam logic [1:0] LINK_PRESENCE   = 2'd1;
  localparam logic [1:0] LINK_READY      = 2'd2;
  localparam logic [1:0] LINK_BUSY       = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] CFG_PRESENCE_LOW  = 3'd2;
  localparam logic [2:0] CFG_SAMPLE_DELAY  = 3'd3;
  localparam logic [2:0] CFG_ZERO_LOW      = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT       = 3'd5;

  // saturation limits of the counters
  localparam logic [9:0]  LOW_COUNT_MAX  = 10'd1023;
  localparam logic [15:0] IDLE_COUNT_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_WAIT_RESET = 4'd0,
    PH_PRES_HIGH  = 4'd1,
    PH_PRES_DELAY = 4'd2,
    PH_PRES_DRIVE = 4'd3,
    PH_READY      = 4'd4,
    PH_RX_HIGH    = 4'd5,
    PH_RX_FALL    = 4'd6,
    PH_RX_SAMPLE  = 4'd7,
    PH_TX_HIGH    = 4'd8,
    PH_TX_FALL    = 4'd9,
    PH_TX_DRIVE   = 4'd10,
    PH_TX_RISE    = 4'd11
  } phase_t;

  typedef struct packed {
    logic       bus_level;
    logic [1:0] req_type;
    logic [7:0] tx_byte;
  } osl_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_done;
    logic       reset_seen;
    logic       timeout_seen;
    logic       req_rejected;
    logic [1:0] link_state;
  } osl_out_t;

  typedef struct packed {
    logic [9:0]  reset_low_ticks;
    logic [7:0]  presence_wait_ticks;
    logic [7:0]  presence_low_ticks;
    logic [5:0]  sample_delay_ticks;
    logic [6:0]  zero_low_ticks;
    logic [15:0] timeout_ticks;
  } osl_cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  shift_reg;
    logic [3:0]  bit_count;
    logic [9:0]  delay_count;
    logic [9:0]  low_count;
    logic [15:0] idle_count;
    logic        prev_level;
    logic        timeout_armed;
    logic        reset_watch_on;
  } osl_state_t;

  localparam osl_cfg_t CFG_RESET = '{
    reset_low_ticks:     10'd480,
    presence_wait_ticks: 8'd15,
    presence_low_ticks:  8'd120,
    sample_delay_ticks:  6'd15,
    zero_low_ticks:      7'd30,
    timeout_ticks:       16'd8192
  };

  localparam osl_state_t STATE_RESET = '{
    phase:          PH_WAIT_RESET,
    shift_reg:      8'd0,
    bit_count:      4'd0,
    delay_count:    10'd0,
    low_count:      10'd0,
    idle_count:     16'd0,
    prev_level:     1'b1,
    timeout_armed:  1'b0,
    reset_watch_on: 1'b1
  };

  // a zero tick count behaves as one
  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // user-visible link state of a phase
  function automatic logic [1:0] link_of(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_PRES_HIGH, PH_PRES_DELAY, PH_PRES_DRIVE: code = LINK_PRESENCE;
      PH_READY: code = LINK_READY;
      PH_RX_HIGH, PH_RX_FALL, PH_RX_SAMPLE,
      PH_TX_HIGH, PH_TX_FALL, PH_TX_DRIVE, PH_TX_RISE: code = LINK_BUSY;
      default: code = LINK_WAIT_RESET;
    endcase
    return code;
  endfunction

endpackage

/* hdl/osl_step.sv */
// ----------------------------------------------------------------------------
// osl_step
// one bus tick of the link layer: next state and result from state and item
// ----------------------------------------------------------------------------
module osl_step import osl_pkg::*; (
  input  osl_state_t state,
  input  osl_cfg_t   cfg,
  input  osl_in_t    item,
  output osl_state_t state_next,
  output osl_out_t   res
);

  osl_state_t st;
  osl_out_t   r;
  logic       lvl;
  logic       fall;
  logic       tmo;
  logic [2:0] sh;

  always_comb begin
    st   = state;
    r    = '0;
    lvl  = item.bus_level;
    fall = state.prev_level & ~item.bus_level;
    tmo  = 1'b0;
    sh   = state.bit_count[2:0];

    // low time follows the sampled bus, saturating
    if (!lvl) begin
      if (st.low_count != LOW_COUNT_MAX) st.low_count = st.low_count + 10'd1;
    end else begin
      st.low_count = '0;
    end

    // bad requests, and requests outside the ready phase, are refused
    if (item.req_type == REQ_BAD) begin
      r.req_rejected = 1'b1;
    end else if (item.req_type != REQ_NONE && state.phase != PH_READY) begin
      r.req_rejected = 1'b1;
    end

    if (!lvl && st.reset_watch_on &&
        16'(st.low_count) >= at_least_one(16'(cfg.reset_low_ticks))) begin
      // master reset wins over everything else
      r.reset_seen      = 1'b1;
      st.reset_watch_on = 1'b0;
      st.timeout_armed  = 1'b1;
      st.idle_count     = '0;
      st.phase          = PH_PRES_HIGH;
      st.delay_count    = '0;
    end else begin
      // session timeout on a long gap between falling edges
      if (st.timeout_armed) begin
        if (fall) st.idle_count = '0;
        else if (st.idle_count != IDLE_COUNT_MAX) st.idle_count = st.idle_count + 16'd1;
        if (st.idle_count >= at_least_one(cfg.timeout_ticks)) begin
          tmo               = 1'b1;
          r.timeout_seen    = 1'b1;
          st.timeout_armed  = 1'b0;
          st.idle_count     = '0;
          st.reset_watch_on = 1'b1;
          st.phase          = PH_WAIT_RESET;
        end
      end

      if (!tmo) begin
        case (st.phase)
          PH_PRES_HIGH: begin
            if (lvl) begin
              st.phase       = PH_PRES_DELAY;
              st.delay_count = '0;
            end
          end
          PH_PRES_DELAY: begin
            if (st.delay_count >= 10'(cfg.presence_wait_ticks)) begin
              st.phase       = PH_PRES_DRIVE;
              r.drive_low    = 1'b1;
              st.delay_count = 10'd1;
            end else begin
              st.delay_count = st.delay_count + 10'd1;
            end
          end
          PH_PRES_DRIVE: begin
            if (16'(st.delay_count) >= at_least_one(16'(cfg.presence_low_ticks))) begin
              st.phase          = PH_READY;
              st.reset_watch_on = 1'b1;
              st.delay_count    = '0;
            end else begin
              r.drive_low    = 1'b1;
              st.delay_count = st.delay_count + 10'd1;
            end
          end
          PH_READY: begin
            if (item.req_type == REQ_RX) begin
              st.phase     = PH_RX_HIGH;
              st.shift_reg = '0;
              st.bit_count = '0;
            end else if (item.req_type == REQ_TX) begin
              st.phase     = PH_TX_HIGH;
              st.shift_reg = item.tx_byte;
              st.bit_count = '0;
            end
          end
          PH_RX_HIGH: begin
            if (lvl) st.phase = PH_RX_FALL;
          end
          PH_RX_FALL: begin
            if (!lvl) begin
              st.phase       = PH_RX_SAMPLE;
              st.delay_count = '0;
            end
          end
          PH_RX_SAMPLE: begin
            // sample the bit the configured sample delay after its falling edge
            st.delay_count = st.delay_count + 10'd1;
            if (16'(st.delay_count) >= at_least_one(16'(cfg.sample_delay_ticks))) begin
              st.shift_reg   = st.shift_reg | (8'(lvl) << sh);
              st.bit_count   = st.bit_count + 4'd1;
              st.delay_count = '0;
              if (32'(st.bit_count) >= BITS_PER_BYTE) begin
                r.rx_valid = 1'b1;
                r.rx_byte  = st.shift_reg;
                st.phase   = PH_READY;
              end else begin
                st.phase = PH_RX_HIGH;
              end
            end
          end
          PH_TX_HIGH: begin
            if (lvl) st.phase = PH_TX_FALL;
          end
          PH_TX_FALL: begin
            if (!lvl) begin
              if (st.shift_reg[0]) begin
                st.phase = PH_TX_RISE;
              end else begin
                st.phase       = PH_TX_DRIVE;
                r.drive_low    = 1'b1;
                st.delay_count = 10'd1;
              end
            end
          end
          PH_TX_DRIVE: begin
            // zero bit held low, then the bit is done
            if (16'(st.delay_count) >= at_least_one(16'(cfg.zero_low_ticks))) begin
              st.delay_count = '0;
              st.shift_reg   = st.shift_reg >> 1;
              st.bit_count   = st.bit_count + 4'd1;
              if (32'(st.bit_count) >= BITS_PER_BYTE) begin
                st.phase  = PH_READY;
                r.tx_done = 1'b1;
              end else begin
                st.phase = PH_TX_HIGH;
              end
            end else begin
              r.drive_low    = 1'b1;
              st.delay_count = st.delay_count + 10'd1;
            end
          end
          PH_TX_RISE: begin
            // one bit ends when the master releases the bus
            if (lvl) begin
              st.shift_reg = st.shift_reg >> 1;
              st.bit_count = st.bit_count + 4'd1;
              if (32'(st.bit_count) >= BITS_PER_BYTE) begin
                st.phase  = PH_READY;
                r.tx_done = 1'b1;
              end else begin
                st.phase = PH_TX_FALL;
              end
            end
          end
          // waiting for reset and unused codes
          default: begin
            st.phase = PH_WAIT_RESET;
          end
        endcase
      end
    end

    st.prev_level = lvl;
    r.link_state  = link_of(st.phase);
    state_next    = st;
    res           = r;
  end

endmodule

/* hdl/onewire_slave_link_core.sv */
// ----------------------------------------------------------------------------
// onewire_slave_link_core
// one-wire slave link layer: reset detect, presence, byte receive and send
// ----------------------------------------------------------------------------
// Each request carries one sampled bus level (one tick) and an optional byte
// receive or send command; each produces exactly one result with the bus
// drive and event flags for that tick. The block takes one request per
// clock unless its buffers are full: a request is registered, stepped
// through the link state and written to the result register. A two-entry
// result buffer (result register plus skid register) keeps requests flowing
// while a result waits; requests stall only when both entries are full.
// Configuration writes are accepted every cycle and take effect on the
// next tick stepped.
module onewire_slave_link_core import osl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  osl_in_t     item,
  output logic        result_valid,
  input  logic        result_ready,
  output osl_out_t    result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  osl_cfg_t   cfg;
  osl_state_t state;
  osl_state_t state_next;
  osl_out_t   step_res;

  logic       stage_valid;
  osl_in_t    stage_item;
  logic       skid_valid;
  osl_out_t   skid;
  logic       fire;
  logic       pop;

  assign cfg_ready  = 1'b1;
  assign fire       = stage_valid & ~skid_valid;
  assign pop        = result_valid & result_ready;
  assign item_ready = ~stage_valid | fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESET_LOW:     cfg.reset_low_ticks     <= cfg_data[9:0];
        CFG_PRESENCE_WAIT: cfg.presence_wait_ticks <= cfg_data[7:0];
        CFG_PRESENCE_LOW:  cfg.presence_low_ticks  <= cfg_data[7:0];
        CFG_SAMPLE_DELAY:  cfg.sample_delay_ticks  <= cfg_data[5:0];
        CFG_ZERO_LOW:      cfg.zero_low_ticks      <= cfg_data[6:0];
        CFG_TIMEOUT:       cfg.timeout_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  // tick logic
  osl_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (stage_item),
    .state_next (state_next),
    .res        (step_res)
  );

  // link state advances once per stepped request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || pop) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= fire;
      end
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || pop) begin
      if (skid_valid) begin
        result <= skid;
      end else if (fire) begin
        result <= step_res;
      end
    end else if (fire) begin
      skid <= step_res;
    end
  end

endmodule

/* hdl/osl_checker.sv */
// ----------------------------------------------------------------------------
// osl_checker
// port-level checks of the one-wire slave link results
// ----------------------------------------------------------------------------
`include "onewire_slave_link_core_defines.svh"

module osl_checker import osl_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     result_valid,
  input logic     result_ready,
  input osl_out_t result
);

  // a stalled result holds
  `OSL_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

  // a finished byte always leaves the link ready
  `OSL_ASSERT_IMP(a_byte_end_ready, result_valid && (result.rx_valid || result.tx_done), result.link_state == LINK_READY)

  // a detected reset starts presence and never comes with a timeout
  `OSL_ASSERT_IMP(a_reset_presence, result_valid && result.reset_seen, result.link_state == LINK_PRESENCE && !result.timeout_seen)

  // the bus is only pulled low for presence or a sent zero
  `OSL_ASSERT_IMP(a_drive_phase, result_valid && result.drive_low, result.link_state == LINK_PRESENCE || result.link_state == LINK_BUSY)

  // no received byte value outside a completion
  `OSL_ASSERT_IMP(a_rx_byte_quiet, result_valid && !result.rx_valid, result.rx_byte == 8'd0)

endmodule

bind onewire_slave_link_core osl_checker u_osl_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

/* test/tb_onewire_slave_link_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_onewire_slave_link_core
// self-checking bench for the one-wire slave link layer
// ----------------------------------------------------------------------------
// A bus master model drives one sampled bus level per request: reset pulses,
// receive and send slots, long quiet stretches and random noise. The bus is
// modeled as wired-and, so the slave's predicted pull-down of the previous
// tick holds the sampled level low. A tracking model of the link computes the
// result of every accepted request; results are compared field by field in
// order. Timing registers are reprogrammed between phases while the block is
// idle, with short, zero, extreme and randomized settings. The sender works in
// bursts and the result side stalls on its own pattern, with long hold-offs
// that back the block up into its input.
// ----------------------------------------------------------------------------
module tb_onewire_slave_link_core;
  import osl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // least number of requests sent in the randomized part after the directed phases
  localparam int BULK_ITEMS  = 100;

  // indexes with no register behind them
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  // tracks the link state and holds the results still due from the block
  class link_tracker;
    osl_cfg_t    regs;
    phase_t      ph;
    logic [7:0]  word;
    logic [3:0]  nbits;
    logic [9:0]  wait_cnt;
    logic [9:0]  low_run;
    logic [15:0] quiet_run;
    logic        last_lvl;
    logic        tmo_armed;
    logic        rst_watch;
    logic        pulling;
    osl_out_t    due_results[$];
    int          errors;

    function new();
      regs      = CFG_RESET;
      ph        = PH_WAIT_RESET;
      word      = '0;
      nbits     = '0;
      wait_cnt  = '0;
      low_run   = '0;
      quiet_run = '0;
      last_lvl  = 1'b1;
      tmo_armed = 1'b0;
      rst_watch = 1'b1;
      pulling   = 1'b0;
      errors    = 0;
    endfunction

    // a zero tick count behaves as one
    function int min1(int v);
      return (v == 0) ? 1 : v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_RESET_LOW:     regs.reset_low_ticks     = val[9:0];
        CFG_PRESENCE_WAIT: regs.presence_wait_ticks = val[7:0];
        CFG_PRESENCE_LOW:  regs.presence_low_ticks  = val[7:0];
        CFG_SAMPLE_DELAY:  regs.sample_delay_ticks  = val[5:0];
        CFG_ZERO_LOW:      regs.zero_low_ticks      = val[6:0];
        CFG_TIMEOUT:       regs.timeout_ticks       = val;
        default: ;
      endcase
    endfunction

    // one sent bit is over; returns 1 when the byte is complete
    function logic bit_sent(phase_t next_ph);
      word  = word >> 1;
      nbits = nbits + 4'd1;
      if (nbits >= BITS_PER_BYTE) begin
        ph = PH_READY;
        return 1'b1;
      end
      ph = next_ph;
      return 1'b0;
    endfunction

    function osl_out_t advance_link(osl_in_t x);
      osl_out_t r;
      logic     lvl;
      logic     fall;
      r    = '0;
      lvl  = x.bus_level;
      fall = last_lvl && !lvl;

      if (!lvl) begin
        if (low_run != LOW_COUNT_MAX) low_run = low_run + 10'd1;
      end else begin
        low_run = '0;
      end

      if (x.req_type == REQ_BAD || (x.req_type != REQ_NONE && ph != PH_READY))
        r.req_rejected = 1'b1;

      if (!lvl && rst_watch && low_run >= min1(int'(regs.reset_low_ticks))) begin
        // master reset wins over everything else this tick
        r.reset_seen = 1'b1;
        rst_watch    = 1'b0;
        tmo_armed    = 1'b1;
        quiet_run    = '0;
        ph           = PH_PRES_HIGH;
        wait_cnt     = '0;
      end else begin
        if (tmo_armed) begin
          if (fall) quiet_run = '0;
          else if (quiet_run != IDLE_COUNT_MAX) quiet_run = quiet_run + 16'd1;
          if (quiet_run >= min1(int'(regs.timeout_ticks))) begin
            r.timeout_seen = 1'b1;
            tmo_armed      = 1'b0;
            quiet_run      = '0;
            rst_watch      = 1'b1;
            ph             = PH_WAIT_RESET;
          end
        end
        if (!r.timeout_seen) begin
          case (ph)
            PH_PRES_HIGH: begin
              if (lvl) begin
                ph       = PH_PRES_DELAY;
                wait_cnt = '0;
              end
            end
            PH_PRES_DELAY: begin
              if (wait_cnt >= regs.presence_wait_ticks) begin
                ph          = PH_PRES_DRIVE;
                r.drive_low = 1'b1;
                wait_cnt    = 10'd1;
              end else begin
                wait_cnt = wait_cnt + 10'd1;
              end
            end
            PH_PRES_DRIVE: begin
              if (wait_cnt >= min1(int'(regs.presence_low_ticks))) begin
                ph        = PH_READY;
                rst_watch = 1'b1;
                wait_cnt  = '0;
              end else begin
                r.drive_low = 1'b1;
                wait_cnt    = wait_cnt + 10'd1;
              end
            end
            PH_READY: begin
              if (x.req_type == REQ_RX) begin
                ph    = PH_RX_HIGH;
                word  = '0;
                nbits = '0;
              end else if (x.req_type == REQ_TX) begin
                ph    = PH_TX_HIGH;
                word  = x.tx_byte;
                nbits = '0;
              end
            end
            PH_RX_HIGH: begin
              if (lvl) ph = PH_RX_FALL;
            end
            PH_RX_FALL: begin
              if (!lvl) begin
                ph       = PH_RX_SAMPLE;
                wait_cnt = '0;
              end
            end
            PH_RX_SAMPLE: begin
              wait_cnt = wait_cnt + 10'd1;
              if (wait_cnt >= min1(int'(regs.sample_delay_ticks))) begin
                word     = word | ({7'd0, lvl} << nbits[2:0]);
                nbits    = nbits + 4'd1;
                wait_cnt = '0;
                if (nbits >= BITS_PER_BYTE) begin
                  r.rx_valid = 1'b1;
                  r.rx_byte  = word;
                  ph         = PH_READY;
                end else begin
                  ph = PH_RX_HIGH;
                end
              end
            end
            PH_TX_HIGH: begin
              if (lvl) ph = PH_TX_FALL;
            end
            PH_TX_FALL: begin
              if (!lvl) begin
                if (word[0]) begin
                  ph = PH_TX_RISE;
                end else begin
                  ph          = PH_TX_DRIVE;
                  r.drive_low = 1'b1;
                  wait_cnt    = 10'd1;
                end
              end
            end
            PH_TX_DRIVE: begin
              if (wait_cnt >= min1(int'(regs.zero_low_ticks))) begin
                wait_cnt  = '0;
                r.tx_done = bit_sent(PH_TX_HIGH);
              end else begin
                r.drive_low = 1'b1;
                wait_cnt    = wait_cnt + 10'd1;
              end
            end
            PH_TX_RISE: begin
              if (lvl) r.tx_done = bit_sent(PH_TX_FALL);
            end
            default: ph = PH_WAIT_RESET;
          endcase
        end
      end

      last_lvl = lvl;
      case (ph)
        PH_PRES_HIGH, PH_PRES_DELAY, PH_PRES_DRIVE: r.link_state = LINK_PRESENCE;
        PH_READY: r.link_state = LINK_READY;
        PH_RX_HIGH, PH_RX_FALL, PH_RX_SAMPLE,
        PH_TX_HIGH, PH_TX_FALL, PH_TX_DRIVE, PH_TX_RISE: r.link_state = LINK_BUSY;
        default: r.link_state = LINK_WAIT_RESET;
      endcase
      return r;
    endfunction

    function void note_request(osl_in_t x);
      osl_out_t r;
      r = advance_link(x);
      pulling = r.drive_low;
      due_results.push_back(r);
    endfunction

    function void compare_field(string fname, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", fname, want, got);
        errors++;
      end
    endfunction

    function void check_result(osl_out_t got);
      osl_out_t want;
      if (due_results.size() == 0) begin
        $error("result %h with no request pending", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("drive_low",    8'(want.drive_low),    8'(got.drive_low));
      compare_field("rx_valid",     8'(want.rx_valid),     8'(got.rx_valid));
      compare_field("rx_byte",      want.rx_byte,          got.rx_byte);
      compare_field("tx_done",      8'(want.tx_done),      8'(got.tx_done));
      compare_field("reset_seen",   8'(want.reset_seen),   8'(got.reset_seen));
      compare_field("timeout_seen", 8'(want.timeout_seen), 8'(got.timeout_seen));
      compare_field("req_rejected", 8'(want.req_rejected), 8'(got.req_rejected));
      compare_field("link_state",   8'(want.link_state),   8'(got.link_state));
    endfunction
  endclass

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  osl_in_t     item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  osl_out_t    result;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;

  link_tracker link = new();
  int cycle_no   = 0;
  int hold_left  = 0;
  int burst_left = 0;
  int items_sent = 0;

  onewire_slave_link_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: check, then pick the next stall from a slowly changing pattern
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst && result_valid && result_ready) link.check_result(result);
    if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (cycle_no % 6000 == 1500) begin
      // long hold-off so the block backs up into its input
      result_ready <= 1'b0;
      hold_left    <= 300;
    end else begin
      case ((cycle_no / 300) % 4)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(0, 1) == 1);
        2: result_ready <= (cycle_no % 4 != 0);
        default: result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // run limit
  initial begin
    wait (cycle_no >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // request code that is mostly none, now and then anything
  function automatic logic [1:0] stray_req();
    logic [1:0] rq;
    rq = 2'($urandom_range(0, 3));
    return ($urandom_range(0, 15) == 0) ? rq : REQ_NONE;
  endfunction

  // one bus tick: the master's level anded with the slave's last pull-down
  task automatic tick(input logic mlvl, input logic [1:0] rq, input logic [7:0] txb);
    osl_in_t pkt;
    int      gap;
    pkt.bus_level = mlvl & ~link.pulling;
    pkt.req_type  = rq;
    pkt.tx_byte   = txb;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item       <= pkt;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    link.note_request(pkt);
    items_sent++;
  endtask

  // stop sending and wait for every result to come back
  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    while (link.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    link.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] rl, input logic [15:0] pw,
                           input logic [15:0] pl, input logic [15:0] sd,
                           input logic [15:0] zl, input logic [15:0] tmo);
    settle();
    write_reg(CFG_RESET_LOW,     rl);
    write_reg(CFG_PRESENCE_WAIT, pw);
    write_reg(CFG_PRESENCE_LOW,  pl);
    write_reg(CFG_SAMPLE_DELAY,  sd);
    write_reg(CFG_ZERO_LOW,      zl);
    write_reg(CFG_TIMEOUT,       tmo);
  endtask

  // master write slot: a short low reads as one, a long low as zero
  task automatic rx_slot();
    int sd;
    int lo;
    sd = link.min1(int'(link.regs.sample_delay_ticks));
    lo = $urandom_range(1, sd + 2);
    repeat ($urandom_range(1, 3)) tick(1'b1, stray_req(), 8'($urandom));
    repeat (lo) tick(1'b0, stray_req(), 8'($urandom));
    repeat ((lo > sd) ? 1 : sd - lo + 1) tick(1'b1, stray_req(), 8'($urandom));
  endtask

  // master read slot: short low, then release until the slave lets go
  task automatic tx_slot();
    repeat ($urandom_range(1, 3)) tick(1'b1, stray_req(), 8'($urandom));
    repeat ($urandom_range(1, 3)) tick(1'b0, stray_req(), 8'($urandom));
    while (link.pulling) tick(1'b1, stray_req(), 8'($urandom));
    repeat ($urandom_range(1, 2)) tick(1'b1, stray_req(), 8'($urandom));
  endtask

  // reset pulse, presence, then up to max_bytes bytes, each a receive or a send
  task automatic run_session(input int max_bytes);
    int         n;
    int         rl;
    int         guard;
    int         tmo;
    int         abort_at;
    logic [1:0] op;
    rl = link.min1(int'(link.regs.reset_low_ticks));
    n  = rl + $urandom_range(0, 6);
    // now and then a pulse too short to count as a reset
    if ($urandom_range(0, 7) == 0 && rl > 1) n = $urandom_range(1, rl - 1);
    repeat (n) tick(1'b0, stray_req(), 8'($urandom));
    guard = link.regs.presence_wait_ticks +
            link.min1(int'(link.regs.presence_low_ticks)) + 6;
    while (link.ph != PH_READY && guard > 0) begin
      tick(1'b1, stray_req(), 8'($urandom));
      guard--;
    end
    for (int b = $urandom_range(1, max_bytes); b > 0; b--) begin
      if (link.ph != PH_READY) break;
      tmo = link.min1(int'(link.regs.timeout_ticks));
      if ($urandom_range(0, 9) == 0 && tmo < 400) begin
        // stay quiet until the session times out
        repeat (tmo + 2) tick(1'b1, REQ_NONE, 8'($urandom));
        break;
      end
      op = ($urandom_range(0, 1) == 1) ? REQ_RX : REQ_TX;
      tick(1'b1, op, 8'($urandom));
      abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : BITS_PER_BYTE;
      for (int k = 0; k < BITS_PER_BYTE; k++) begin
        if (k == abort_at) break;
        if (op == REQ_RX) rx_slot();
        else tx_slot();
      end
      // a cut byte is left to the next reset pulse
      if (abort_at < BITS_PER_BYTE) break;
      repeat ($urandom_range(1, 3)) tick(1'b1, stray_req(), 8'($urandom));
    end
  endtask

  task automatic run_phase(input int sessions, input int min_items, input int max_bytes);
    int start;
    int done;
    repeat (10) tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 8'($urandom));
    start = items_sent;
    done  = 0;
    while (done < sessions || items_sent - start < min_items) begin
      run_session(max_bytes);
      done++;
    end
  endtask

  initial begin
    int bulk_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // requests while waiting for a reset, with the byte extremes
    tick(1'b1, REQ_RX,   8'h00);
    tick(1'b1, REQ_TX,   8'hFF);
    tick(1'b1, REQ_BAD,  8'hA5);
    tick(1'b0, REQ_NONE, 8'h5A);
    tick(1'b1, REQ_NONE, 8'h00);
    // short timings: reset, presence, then a receive cut short by a reset
    load_regs(16'd2, 16'd0, 16'd1, 16'd1, 16'd1, 16'd20);
    repeat (2) tick(1'b0, REQ_NONE, 8'h00);
    repeat (3) tick(1'b1, REQ_NONE, 8'h00);
    tick(1'b1, REQ_BAD,  8'h00);
    tick(1'b1, REQ_RX,   8'hFF);
    tick(1'b1, REQ_NONE, 8'h00);
    tick(1'b0, REQ_TX,   8'hFF);
    tick(1'b1, REQ_NONE, 8'h00);
    repeat (2) tick(1'b0, REQ_NONE, 8'h00);
    // presence again, then an own zero bit long enough to count as a reset
    repeat (3) tick(1'b1, REQ_NONE, 8'h00);
    tick(1'b1, REQ_TX,   8'h00);
    tick(1'b1, REQ_NONE, 8'h00);
    tick(1'b0, REQ_NONE, 8'h00);
    repeat (2) tick(1'b1, REQ_NONE, 8'h00);

    // moderate timings, plus writes to indexes with no register
    load_regs(16'd6, 16'd3, 16'd4, 16'd3, 16'd5, 16'd80);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h1234);
    run_phase(2, 0, 2);
    // shortest timings, session times out right away
    load_regs(16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
    run_phase(3, 0, 2);
    // every count zero after the upper bits are dropped
    load_regs(16'hFC00, 16'hFF00, 16'h0000, 16'hFFC0, 16'hFF80, 16'h0000);
    run_phase(3, 0, 2);
    // zero counts with a usable reset length and timeout
    load_regs(16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd50);
    run_phase(1, 0, 2);
    // longest presence and no timeout to speak of
    load_regs(16'd8, 16'd255, 16'd255, 16'd2, 16'd3, 16'hFFFF);
    run_phase(1, 0, 1);
    // longest sample delay and zero bits that outlast the reset length
    load_regs(16'd100, 16'd1, 16'd2, 16'd63, 16'd127, 16'd4000);
    run_phase(1, 0, 1);

    // randomized short timings, now and then a tight timeout
    bulk_start = items_sent;
    while (items_sent - bulk_start < BULK_ITEMS) begin
      load_regs(16'($urandom_range(8, 14)), 16'($urandom_range(0, 5)),
                16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                16'($urandom_range(1, 5)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(5, 15))
                                            : 16'($urandom_range(40, 150)));
      run_phase(0, 50, 4);
    end

    settle();
    if (link.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
